// ===== sv/cpnl_pkg.sv =====
package cpnl_pkg;

  localparam int MAX_NEIGHBORS = 1024;
  localparam int NB_AW         = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W         = NB_AW + 1;
  localparam int PT_W          = 16;
  localparam int FRC_W         = 64;
  localparam int RAM_AW        = NB_AW + 1;
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OBS_MARGN = CFG_IDX_W'(3);

  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_FORCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_APPEND
  } state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic [30:0]        obstacle_margin;
    logic [30:0]        min_dist;
    logic [30:0]        point_margin;
  } calc_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } calc_rsp_t;

endpackage

// ===== sv/cpnl_if.sv =====
interface cpnl_item_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [30:0]        min_dist;
  logic [30:0]        point_margin;
  logic               last_of_pass;
  logic [9:0]         slot;
  logic signed [31:0] force_normal_in;
  logic signed [31:0] force_tangent_in;

  modport source (output valid, command, pos_x, pos_y, min_dist, point_margin,
                  last_of_pass, slot, force_normal_in, force_tangent_in,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, min_dist, point_margin,
                last_of_pass, slot, force_normal_in, force_tangent_in,
                output ready);
endinterface

interface cpnl_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        neighbor_index;
  logic signed [31:0] force_normal;
  logic signed [31:0] force_tangent;
  logic               carried;
  logic               overflow;

  modport source (output valid, neighbor_index, force_normal, force_tangent,
                  carried, overflow, input ready);
  modport sink (input valid, neighbor_index, force_normal, force_tangent,
                carried, overflow, output ready);
endinterface

// ===== sv/cpnl_ram.sv =====
module cpnl_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/cpnl_calc.sv =====
module cpnl_calc import cpnl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  calc_req_t req,
  output calc_rsp_t rsp
);

  // stage 1: magnitudes and reach
  logic signed [32:0] dx, dy;
  logic [31:0]        thr;
  logic [32:0]        mag_x, mag_y, reach;
  logic               v1;
  // stage 2: squares
  logic [65:0]        sq_x, sq_y, sq_r;
  logic               v2;
  // stage 3: compare
  logic               v3, hit;

  always_comb begin
    dx  = 33'(req.pos_x) - 33'(req.center_x);
    dy  = 33'(req.pos_y) - 33'(req.center_y);
    thr = 32'(req.point_margin) + 32'(req.obstacle_margin);
    if (thr < 32'(req.min_dist)) begin
      thr = 32'(req.min_dist);
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= dx[32] ? 33'(-dx) : 33'(dx);
    mag_y <= dy[32] ? 33'(-dy) : 33'(dy);
    reach <= 33'(req.radius) + 33'(thr);
    sq_x  <= 66'(mag_x) * 66'(mag_x);
    sq_y  <= 66'(mag_y) * 66'(mag_y);
    sq_r  <= 66'(reach) * 66'(reach);
    hit   <= (67'(sq_x) + 67'(sq_y)) < 67'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign rsp.done = v3;
  assign rsp.hit  = hit;

endmodule

// ===== sv/circle_proximity_neighbor_list.sv =====
// Circle obstacle proximity list with contact force carry-over.
// Channels: "item" (sink) takes material points (command 0) in index order
// and force writes (command 1); "result" (source) returns one transaction per
// point found within reach of the obstacle. Config is a plain write port
// (cfg_we, cfg_index, cfg_data): 0 center_x, 1 center_y, 2 radius,
// 3 obstacle_margin; other indexes are ignored.
// Sequence: a force write is taken in idle. A point passes through the
// three-stage distance unit and then returns to idle before the next item,
// so a non-neighbor ends there. A neighbor then runs the merge: a RAM read
// state and a compare state per old list entry the merge compares, a further
// read state when the merge runs off the end of the old list, and an append
// state, which waits while the result register is still held.
// Index and force RAMs each hold both lists in two banks; a pass end swaps
// the banks by flipping a bank bit, so no copying is done.
// Reset: config, counts, merge pointer and point counter clear; list
// contents are not cleared and are only read below the counts.
// Result stall: the result register holds the transaction; the block keeps
// accepting items until it needs the register for the next neighbor.
module circle_proximity_neighbor_list import cpnl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  cpnl_item_if.sink            item,
  cpnl_result_if.source        result
);

  // configuration
  logic signed [31:0] center_x, center_y;
  logic [30:0]        radius, obstacle_margin;

  // control state
  state_t           state, state_next;
  logic             bank_new;
  logic [CNT_W-1:0] old_count, new_count, merge_ptr;
  logic [PT_W-1:0]  point_ctr;
  logic             last_q;
  logic             carried_q;
  logic [63:0]      forces_q;

  // list RAMs: index and forces
  logic                append_we;
  logic                frc_we;
  logic [RAM_AW-1:0]   app_addr, frc_waddr, ram_raddr;
  logic [FRC_W-1:0]    frc_wdata, frc_rdata;
  logic [PT_W-1:0]     rd_index;

  calc_req_t calc_req;
  calc_rsp_t calc_rsp;

  logic accept, force_wr, start_calc, out_free, finish, list_full;
  logic [CNT_W-1:0] count_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      radius          <= '0;
      obstacle_margin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_x        <= cfg_data;
        REG_CENTER_Y:  center_y        <= cfg_data;
        REG_RADIUS:    radius          <= cfg_data[30:0];
        REG_OBS_MARGN: obstacle_margin <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign force_wr   = accept && (item.command == CMD_FORCE) &&
                      (CNT_W'(item.slot) < old_count);
  assign start_calc = accept && (item.command == CMD_TEST);
  assign out_free   = !result.valid || result.ready;
  assign list_full  = (new_count == CNT_W'(MAX_NEIGHBORS));

  assign calc_req.pos_x           = item.pos_x;
  assign calc_req.pos_y           = item.pos_y;
  assign calc_req.center_x        = center_x;
  assign calc_req.center_y        = center_y;
  assign calc_req.radius          = radius;
  assign calc_req.obstacle_margin = obstacle_margin;
  assign calc_req.min_dist        = item.min_dist;
  assign calc_req.point_margin    = item.point_margin;

  cpnl_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (start_calc),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  // Force writes touch only the old bank of the force RAM, and only while
  // idle; the merge reads the old bank and appends go to the new bank, so
  // accesses never collide. A force write leaves the stored index alone.
  assign append_we = (state == ST_APPEND) && out_free && !list_full;
  assign app_addr  = {bank_new, new_count[NB_AW-1:0]};

  always_comb begin
    frc_we    = 1'b0;
    frc_waddr = app_addr;
    frc_wdata = forces_q;
    if (force_wr) begin
      frc_we    = 1'b1;
      frc_waddr = {~bank_new, item.slot};
      frc_wdata = {item.force_tangent_in, item.force_normal_in};
    end else if (append_we) begin
      frc_we = 1'b1;
    end
  end

  assign ram_raddr = {~bank_new, merge_ptr[NB_AW-1:0]};

  cpnl_ram #(
    .DEPTH (2 * MAX_NEIGHBORS),
    .WIDTH (PT_W)
  ) u_idx_ram (
    .clk   (clk),
    .we    (append_we),
    .waddr (app_addr),
    .wdata (point_ctr),
    .raddr (ram_raddr),
    .rdata (rd_index)
  );

  cpnl_ram #(
    .DEPTH (2 * MAX_NEIGHBORS),
    .WIDTH (FRC_W)
  ) u_frc_ram (
    .clk   (clk),
    .we    (frc_we),
    .waddr (frc_waddr),
    .wdata (frc_wdata),
    .raddr (ram_raddr),
    .rdata (frc_rdata)
  );

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_calc) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_rsp.done) begin
          if (calc_rsp.hit) begin
            state_next = ST_SCAN_RD;
          end else begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN_RD: begin
        state_next = (merge_ptr < old_count) ? ST_SCAN_CMP : ST_APPEND;
      end
      ST_SCAN_CMP: begin
        state_next = (rd_index < point_ctr) ? ST_SCAN_RD : ST_APPEND;
      end
      ST_APPEND: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign count_after = (state == ST_APPEND && !list_full) ?
                       new_count + CNT_W'(1) : new_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bank_new  <= 1'b0;
      old_count <= '0;
      new_count <= '0;
      merge_ptr <= '0;
      point_ctr <= '0;
      carried_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CALC) begin
        carried_q <= 1'b0;
      end
      if (state == ST_SCAN_CMP && rd_index <= point_ctr) begin
        merge_ptr <= merge_ptr + CNT_W'(1);
        if (rd_index == point_ctr) begin
          carried_q <= 1'b1;
        end
      end
      if (finish) begin
        if (last_q) begin
          bank_new  <= ~bank_new;
          old_count <= count_after;
          new_count <= '0;
          merge_ptr <= '0;
          point_ctr <= '0;
        end else begin
          new_count <= count_after;
          point_ctr <= point_ctr + PT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= item.last_of_pass;
    end
    if (state == ST_CALC) begin
      forces_q <= '0;
    end else if (state == ST_SCAN_CMP && rd_index == point_ctr) begin
      forces_q <= frc_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_APPEND && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPEND && out_free) begin
      result.neighbor_index <= point_ctr;
      result.force_normal   <= forces_q[31:0];
      result.force_tangent  <= forces_q[63:32];
      result.carried        <= carried_q;
      result.overflow       <= list_full;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    merge_ptr <= old_count) else $error("merge pointer past old list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    new_count <= CNT_W'(MAX_NEIGHBORS)) else $error("new list count too large");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND && result.valid && !result.ready) |=> $stable(new_count))
    else $error("append while result stalled");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CMP) |-> !item.ready) else $error("ready during merge");
`endif

endmodule
